// ===== hw/rtl/ggvc_pkg.sv =====
package ggvc_pkg;

  // Field widths of the channels.
  localparam int POS_W      = 32;
  localparam int ANG_W      = 16;
  localparam int SPD_W      = 16;
  localparam int DRV_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Commands of an input item.
  localparam logic CMD_TARGET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_DIST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE  = 3'd4;

  // Register values after reset.
  localparam logic [15:0] RST_MAX_LIN    = 16'd3686;
  localparam logic [15:0] RST_APP_GAIN   = 16'd128;
  localparam logic [15:0] RST_TURN_GAIN  = 16'd3277;
  localparam logic [23:0] RST_BRAKE_DIST = 24'd4424;
  localparam logic [15:0] RST_OUT_SCALE  = 16'd2076;

  // Angle thresholds in Q30 radians.
  localparam longint Q30_PI   = 64'sd3373259426;
  localparam longint Q30_DEAD = 64'sd53687091;
  localparam longint Q30_FAST = 64'sd858993459;
  localparam longint Q30_FWD  = 64'sd644245094;

  // One meter in Q.8 and the standstill speed in Q8.8.
  localparam int ONE_METER   = 256;
  localparam int STILL_SPEED = 25;

  // Arc tangent of 2^-i in Q30 radians, truncated.
  function automatic logic [30:0] cordic_atan(input logic [4:0] idx);
    logic [30:0] val;
    case (idx)
      5'd0:  val = 31'd843314856;
      5'd1:  val = 31'd497837829;
      5'd2:  val = 31'd263043836;
      5'd3:  val = 31'd133525158;
      5'd4:  val = 31'd67021686;
      5'd5:  val = 31'd33543515;
      5'd6:  val = 31'd16775850;
      5'd7:  val = 31'd8388437;
      5'd8:  val = 31'd4194282;
      5'd9:  val = 31'd2097149;
      5'd10: val = 31'd1048575;
      5'd11: val = 31'd524287;
      5'd12: val = 31'd262143;
      5'd13: val = 31'd131071;
      5'd14: val = 31'd65535;
      5'd15: val = 31'd32767;
      5'd16: val = 31'd16383;
      5'd17: val = 31'd8191;
      5'd18: val = 31'd4095;
      5'd19: val = 31'd2047;
      5'd20: val = 31'd1023;
      5'd21: val = 31'd511;
      5'd22: val = 31'd255;
      5'd23: val = 31'd127;
      5'd24: val = 31'd63;
      5'd25: val = 31'd31;
      5'd26: val = 31'd15;
      5'd27: val = 31'd7;
      5'd28: val = 31'd3;
      5'd29: val = 31'd1;
      default: val = 31'd0;
    endcase
    return val;
  endfunction

  // Saturates a wide signed value to a 16 bit drive.
  function automatic logic signed [15:0] sat16(input logic signed [71:0] v);
    logic signed [15:0] r;
    if (v > 72'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -72'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ggvc_in_if.sv =====
interface ggvc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic signed [ggvc_pkg::POS_W-1:0]    goal_x;
  logic signed [ggvc_pkg::POS_W-1:0]    goal_y;
  logic signed [ggvc_pkg::POS_W-1:0]    pos_x;
  logic signed [ggvc_pkg::POS_W-1:0]    pos_y;
  logic signed [ggvc_pkg::ANG_W-1:0]    heading;
  logic signed [ggvc_pkg::SPD_W-1:0]    speed;

  modport source(output valid, cmd, goal_x, goal_y, pos_x, pos_y, heading, speed,
                 input ready);
  modport sink(input valid, cmd, goal_x, goal_y, pos_x, pos_y, heading, speed,
               output ready);
endinterface

// ===== hw/rtl/ggvc_out_if.sv =====
interface ggvc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ggvc_pkg::DRV_W-1:0] linear_drive;
  logic signed [ggvc_pkg::DRV_W-1:0] angular_drive;
  logic                              reached;
  logic                              armed;

  modport source(output valid, linear_drive, angular_drive, reached, armed,
                 input ready);
  modport sink(input valid, linear_drive, angular_drive, reached, armed,
               output ready);
endinterface

// ===== hw/rtl/ggvc_cfg_if.sv =====
interface ggvc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ggvc_pkg::CFG_IDX_W-1:0]      index;
  logic [ggvc_pkg::CFG_DATA_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/go_to_goal_velocity_controller_unit.sv =====
// Go-to-goal proportional controller for a differential-drive vehicle.
//
// The input channel (in_if) carries one item per command. A target item stores
// the goal and arms the controller; a tick item carries the odometry pose,
// heading and speed. Every accepted item gives exactly one result item on
// out_if: the scaled linear and angular drives, a reached flag and the armed
// state after the item. Registers are written through cfg_if, which is always
// ready; indexes past the last register are ignored.
//
// A target item, or a tick while disarmed, goes from acceptance straight to
// S_DONE, which loads the result register. An armed tick passes through the
// normalizing shifts, the CORDIC rotations, the squares, the square root and
// the gain and scaling products; with the goal at the current position the
// CORDIC is skipped. The 32 steps of the bit-serial square root and the CORDIC
// rotations dominate a tick. One 36 x 36 multiplier, registered, does the
// squares, the gain products and the output scaling in turn. The block takes
// one item at a time: in_if.ready is high only while the sequencer is idle,
// so the next item can be taken in the cycle after the result register loads.
//
// Reset restores the register defaults, clears the stored goal and disarms.
// When the receiver stalls, a finished result waits in the sequencer's last
// step until the output register frees, and the held result stays stable.
module go_to_goal_velocity_controller_unit #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_FRAC_BITS   = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  ggvc_in_if.sink       in_if,
  ggvc_out_if.source    out_if,
  ggvc_cfg_if.sink      cfg_if
);

  // Sequencer steps.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ABS  = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_CORD = 4'd3;
  localparam logic [3:0] S_BEAR = 4'd4;
  localparam logic [3:0] S_SQX  = 4'd5;
  localparam logic [3:0] S_SQY  = 4'd6;
  localparam logic [3:0] S_SQS  = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_ERR  = 4'd9;
  localparam logic [3:0] S_ANGM = 4'd10;
  localparam logic [3:0] S_ANGR = 4'd11;
  localparam logic [3:0] S_LINR = 4'd12;
  localparam logic [3:0] S_SCA  = 4'd13;
  localparam logic [3:0] S_SCL  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  localparam int FS    = 30 - ANGLE_FRAC_BITS;
  localparam int CNT_W = $clog2(CORDIC_ITERATIONS + 1);
  localparam logic [CNT_W-1:0] ITER_C = CNT_W'(CORDIC_ITERATIONS);

  // Angle constants rounded from Q30 to the internal angle format.
  localparam longint RND_Q30 = 64'sd1 <<< (FS - 1);
  localparam logic signed [35:0] PI_F     = 36'((ggvc_pkg::Q30_PI + RND_Q30) >>> FS);
  localparam logic signed [35:0] TWO_PI_F = PI_F <<< 1;
  localparam logic signed [35:0] DEAD_F   = 36'((ggvc_pkg::Q30_DEAD + RND_Q30) >>> FS);
  localparam logic signed [35:0] FAST_F   = 36'((ggvc_pkg::Q30_FAST + RND_Q30) >>> FS);
  localparam logic signed [35:0] FWD_F    = 36'((ggvc_pkg::Q30_FWD + RND_Q30) >>> FS);
  localparam logic signed [35:0] PI_Q30   = 36'(ggvc_pkg::Q30_PI);
  localparam logic signed [35:0] HALF_PI_Q30 = 36'(ggvc_pkg::Q30_PI / 2);
  localparam logic signed [35:0] RND_FS   = 36'sd1 <<< (FS - 1);

  // Heading conversion from Q3.13 to the internal angle format.
  localparam int HUP  = (ANGLE_FRAC_BITS >= 13) ? ANGLE_FRAC_BITS - 13 : 0;
  localparam int HDN  = (ANGLE_FRAC_BITS >= 13) ? 0 : 13 - ANGLE_FRAC_BITS;
  localparam int HDN1 = (HDN > 0) ? HDN - 1 : 0;
  localparam logic signed [35:0] HRND = (HDN > 0) ? (36'sd1 <<< HDN1) : 36'sd0;

  localparam logic signed [71:0] RND_F72 = 72'sd1 <<< (ANGLE_FRAC_BITS - 1);
  localparam logic signed [71:0] RND_8   = 72'sd128;
  localparam logic signed [71:0] RND_16  = 72'sd32768;

  localparam logic signed [15:0] STILL_HI = 16'(ggvc_pkg::STILL_SPEED);
  localparam logic signed [15:0] STILL_LO = -STILL_HI;

  logic [3:0] state_r, state_nxt;

  // Configuration registers.
  logic [15:0] max_lin_r, app_gain_r, turn_gain_r, out_scale_r;
  logic [23:0] brake_r;

  // Controller state.
  logic signed [31:0] goal_x_r, goal_y_r;
  logic               armed_r;

  // Per-tick working registers.
  logic signed [32:0] dx_r, dy_r;
  logic signed [15:0] hd_r, sp_r;
  logic [32:0]        ax_r, ay_r;
  logic               dxn_r, dyn_r, zero_r;
  logic signed [43:0] cx_r, cy_r;
  logic signed [35:0] cz_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [35:0] bear_r;
  logic [63:0]        sum_r, sqv_r, root_r;
  logic [4:0]         sqk_r;
  logic [33:0]        dist_r;
  logic signed [35:0] err_r, aerr_r;
  logic signed [35:0] ang_r, lin_r;
  logic signed [15:0] res_lin_r, res_ang_r;
  logic               res_reached_r;

  // Result register.
  logic               out_valid_r;
  logic signed [15:0] out_lin_r, out_ang_r;
  logic               out_reached_r, out_armed_r;

  // Shared multiplier.
  logic signed [35:0] mul_a, mul_b;
  logic signed [71:0] mul_r;

  logic in_acc, out_free;

  // Absolute differences.
  logic [32:0] dx_abs, dy_abs;

  // CORDIC.
  logic [4:0]         sh;
  logic signed [43:0] xs, ys;
  logic signed [35:0] atn;
  logic [43:0]        cxy_or;
  logic               norm_done, norm_small;
  logic signed [35:0] za, zb, zc, bear_nxt;

  // Square root and distance.
  logic        big;
  logic [31:0] hx, hy;
  logic [63:0] sq_bit, sq_t;
  logic        sq_ge;
  logic [33:0] dist_nxt;

  // Heading error.
  logic signed [35:0] hd_x, hf, e0, e1, e2, ae;

  // Control decisions.
  logic dead, fast, near, far, still;
  logic signed [71:0] r_ang, r_lin, r_sc;
  logic signed [35:0] lin_nxt;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid         = out_valid_r;
  assign out_if.linear_drive  = out_lin_r;
  assign out_if.angular_drive = out_ang_r;
  assign out_if.reached       = out_reached_r;
  assign out_if.armed         = out_armed_r;

  assign dx_abs = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign dy_abs = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);

  // One CORDIC rotation per cycle in vectoring mode.
  assign sh  = 5'(cnt_r);
  assign xs  = cx_r >>> sh;
  assign ys  = cy_r >>> sh;
  assign atn = $signed({5'b0, ggvc_pkg::cordic_atan(sh)});

  // Operands are shifted left until the larger one reaches bit 39.
  assign cxy_or     = cx_r | cy_r;
  assign norm_done  = |cxy_or[43:39];
  assign norm_small = ~|cxy_or[43:32];

  // Clamp the first-quadrant angle, fold it into its quadrant and round it.
  always_comb begin
    if (cz_r < 36'sd0) begin
      za = 36'sd0;
    end else if (cz_r > HALF_PI_Q30) begin
      za = HALF_PI_Q30;
    end else begin
      za = cz_r;
    end
    zb = dxn_r ? PI_Q30 - za : za;
    zc = dyn_r ? -zb : zb;
    bear_nxt = zero_r ? 36'sd0 : (zc + RND_FS) >>> FS;
  end

  // When a difference reaches 2^31 both are halved and the root doubled.
  assign big = ax_r[32] | ax_r[31] | ay_r[32] | ay_r[31];
  assign hx  = big ? ax_r[32:1] : ax_r[31:0];
  assign hy  = big ? ay_r[32:1] : ay_r[31:0];

  // Restoring square root, one result bit per cycle.
  assign sq_bit   = 64'd1 << {sqk_r, 1'b0};
  assign sq_t     = root_r + sq_bit;
  assign sq_ge    = sqv_r >= sq_t;
  assign dist_nxt = big ? {root_r[32:0], 1'b0} : {1'b0, root_r[32:0]};

  // Heading error, wrapped once by two pi.
  always_comb begin
    hd_x = 36'(hd_r);
    if (ANGLE_FRAC_BITS >= 13) begin
      hf = hd_x <<< HUP;
    end else begin
      hf = (hd_x + HRND) >>> HDN;
    end
    e0 = hf - bear_r;
    e1 = (e0 >= PI_F) ? e0 - TWO_PI_F : e0;
    e2 = (e1 < -PI_F) ? e1 + TWO_PI_F : e1;
    ae = (e2 < 36'sd0) ? -e2 : e2;
  end

  assign dead  = aerr_r <= DEAD_F;
  assign fast  = aerr_r < FAST_F;
  assign near  = dist_r <= 34'(ggvc_pkg::ONE_METER);
  assign far   = dist_r > {10'b0, brake_r};
  assign still = (sp_r <= STILL_HI) && (sp_r >= STILL_LO);

  assign r_ang = (mul_r + RND_F72) >>> ANGLE_FRAC_BITS;
  assign r_lin = (mul_r + RND_8) >>> 8;
  assign r_sc  = (mul_r + RND_16) >>> 16;

  always_comb begin
    if (near) begin
      lin_nxt = 36'sd0;
    end else if (far) begin
      lin_nxt = (aerr_r <= FWD_F) ? $signed({20'b0, max_lin_r}) : 36'sd0;
    end else begin
      lin_nxt = 36'(r_lin);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_r)
      S_SQX: begin
        mul_a = $signed({4'b0, hx});
        mul_b = $signed({4'b0, hx});
      end
      S_SQY: begin
        mul_a = $signed({4'b0, hy});
        mul_b = $signed({4'b0, hy});
      end
      S_ANGM: begin
        mul_a = fast ? -err_r : -(err_r <<< 1);
        mul_b = $signed({20'b0, turn_gain_r});
      end
      S_ANGR: begin
        mul_a = $signed({2'b0, dist_r});
        mul_b = $signed({20'b0, app_gain_r});
      end
      S_LINR: begin
        mul_a = near ? 36'sd0 : ang_r;
        mul_b = $signed({20'b0, out_scale_r});
      end
      S_SCA: begin
        mul_a = lin_r;
        mul_b = $signed({20'b0, out_scale_r});
      end
      default: begin
        mul_a = 36'sd0;
        mul_b = 36'sd0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_if.cmd == ggvc_pkg::CMD_TICK && armed_r) begin
            state_nxt = S_ABS;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_ABS: begin
        state_nxt = (dx_abs == 33'd0 && dy_abs == 33'd0) ? S_BEAR : S_NORM;
      end
      S_NORM: begin
        if (norm_done) begin
          state_nxt = S_CORD;
        end
      end
      S_CORD: begin
        if (cnt_r == ITER_C) begin
          state_nxt = S_BEAR;
        end
      end
      S_BEAR: state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_SQS;
      S_SQS:  state_nxt = S_SQRT;
      S_SQRT: begin
        if (sqk_r == 5'd0) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR:  state_nxt = S_ANGM;
      S_ANGM: state_nxt = S_ANGR;
      S_ANGR: state_nxt = S_LINR;
      S_LINR: state_nxt = S_SCA;
      S_SCA:  state_nxt = S_SCL;
      S_SCL:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b0;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      out_valid_r <= 1'b0;
      max_lin_r   <= ggvc_pkg::RST_MAX_LIN;
      app_gain_r  <= ggvc_pkg::RST_APP_GAIN;
      turn_gain_r <= ggvc_pkg::RST_TURN_GAIN;
      brake_r     <= ggvc_pkg::RST_BRAKE_DIST;
      out_scale_r <= ggvc_pkg::RST_OUT_SCALE;
    end else begin
      state_r <= state_nxt;

      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          ggvc_pkg::REG_MAX_LIN:    max_lin_r   <= cfg_if.data[15:0];
          ggvc_pkg::REG_APP_GAIN:   app_gain_r  <= cfg_if.data[15:0];
          ggvc_pkg::REG_TURN_GAIN:  turn_gain_r <= cfg_if.data[15:0];
          ggvc_pkg::REG_BRAKE_DIST: brake_r     <= cfg_if.data;
          ggvc_pkg::REG_OUT_SCALE:  out_scale_r <= cfg_if.data[15:0];
          default: ;
        endcase
      end

      if (in_acc && in_if.cmd == ggvc_pkg::CMD_TARGET) begin
        goal_x_r <= in_if.goal_x;
        goal_y_r <= in_if.goal_y;
        armed_r  <= 1'b1;
      end else if (state_r == S_LINR && near && still) begin
        armed_r <= 1'b0;
      end

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;

    case (state_r)
      S_IDLE: begin
        dx_r <= 33'(goal_x_r) - 33'(in_if.pos_x);
        dy_r <= 33'(goal_y_r) - 33'(in_if.pos_y);
        hd_r <= in_if.heading;
        sp_r <= in_if.speed;
        res_lin_r     <= '0;
        res_ang_r     <= '0;
        res_reached_r <= 1'b0;
      end
      S_ABS: begin
        ax_r   <= dx_abs;
        ay_r   <= dy_abs;
        dxn_r  <= dx_r[32];
        dyn_r  <= dy_r[32];
        zero_r <= (dx_abs == 33'd0 && dy_abs == 33'd0);
        cx_r   <= $signed({11'b0, dx_abs});
        cy_r   <= $signed({11'b0, dy_abs});
        cz_r   <= '0;
        cnt_r  <= '0;
      end
      S_NORM: begin
        if (!norm_done) begin
          if (norm_small) begin
            cx_r <= cx_r <<< 8;
            cy_r <= cy_r <<< 8;
          end else begin
            cx_r <= cx_r <<< 1;
            cy_r <= cy_r <<< 1;
          end
        end
      end
      S_CORD: begin
        if (cnt_r != ITER_C) begin
          if (!cy_r[43]) begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + atn;
          end else begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - atn;
          end
          cnt_r <= cnt_r + 1'b1;
        end
      end
      S_BEAR: begin
        bear_r <= bear_nxt;
      end
      S_SQY: begin
        sum_r <= mul_r[63:0];
      end
      S_SQS: begin
        sqv_r  <= sum_r + mul_r[63:0];
        root_r <= '0;
        sqk_r  <= 5'd31;
      end
      S_SQRT: begin
        if (sq_ge) begin
          sqv_r  <= sqv_r - sq_t;
          root_r <= (root_r >> 1) + sq_bit;
        end else begin
          root_r <= root_r >> 1;
        end
        sqk_r <= sqk_r - 5'd1;
      end
      S_ERR: begin
        dist_r <= dist_nxt;
        err_r  <= e2;
        aerr_r <= ae;
      end
      S_ANGR: begin
        ang_r <= dead ? 36'sd0 : 36'(r_ang);
      end
      S_LINR: begin
        lin_r <= lin_nxt;
        if (near && still) begin
          res_reached_r <= 1'b1;
        end
      end
      S_SCA: begin
        res_ang_r <= ggvc_pkg::sat16(r_sc);
      end
      S_SCL: begin
        res_lin_r <= ggvc_pkg::sat16(r_sc);
      end
      S_DONE: begin
        if (out_free) begin
          out_lin_r     <= res_lin_r;
          out_ang_r     <= res_ang_r;
          out_reached_r <= res_reached_r;
          out_armed_r   <= armed_r;
        end
      end
      default: ;
    endcase
  end

  // A result that declares the goal reached is disarmed and carries no drive.
  a_reached_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_reached_r |-> !out_armed_r && out_lin_r == 16'sd0 &&
    out_ang_r == 16'sd0)
    else $error("reached result with drive or still armed");

  // A target item arms the controller.
  a_target_arms: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_if.cmd == ggvc_pkg::CMD_TARGET |=> armed_r)
    else $error("target item did not arm the controller");

  // The rotation counter never runs past the iteration count.
  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CORD |-> cnt_r <= ITER_C)
    else $error("CORDIC counter overran");

  // The last root step hands over to the error step.
  a_sqrt_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT && sqk_r == 5'd0 |=> state_r == S_ERR)
    else $error("square root did not finish in 32 steps");

endmodule
